[sv/erttr_pkg.sv]
`default_nettype none
package erttr_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int TIME_WIDTH  = 48;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    localparam int SLOT_W      = 7;
    localparam int RTT_W       = 39;
    localparam int NOW_W       = 48;
    localparam int LEN_W       = 16;

    localparam int US_PER_MS   = 1000;
    localparam int REM_W       = $clog2(US_PER_MS);
    localparam int DIV_BITS    = 4;
    localparam int MIN_PAYLOAD = 8;

    localparam logic       OP_SEND         = 1'b0;
    localparam logic       OP_REPLY        = 1'b1;
    localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;

    localparam logic [2:0] ST_TRACKED   = 3'd0;
    localparam logic [2:0] ST_UNTRACKED = 3'd1;
    localparam logic [2:0] ST_MATCHED   = 3'd2;
    localparam logic [2:0] ST_SHORT     = 3'd3;
    localparam logic [2:0] ST_IGNORED   = 3'd4;
    localparam logic [2:0] ST_UNKNOWN   = 3'd5;

    typedef struct packed {
        logic             operation;
        logic [NOW_W-1:0] now_us;
        logic [15:0]      reply_seq;
        logic [7:0]       reply_type;
        logic [15:0]      reply_id;
        logic [LEN_W-1:0] packet_length;
        logic [3:0]       header_words;
    } t_request;

    typedef struct packed {
        logic [2:0]        status;
        logic [15:0]       seq_out;
        logic [SLOT_W-1:0] slot_out;
        logic [RTT_W-1:0]  rtt_ms;
        logic [15:0]       sent_total;
        logic [15:0]       received_total;
    } t_result;

    typedef struct packed {
        logic [15:0]           seq;
        logic [TIME_WIDTH-1:0] stamp;
    } t_slot_entry;

endpackage
`default_nettype wire

[sv/erttr_slot_ram.sv]
`default_nettype none
module erttr_slot_ram (
    input  wire                           i_clk,
    input  wire                           i_we,
    input  wire [erttr_pkg::IDX_W-1:0]    i_waddr,
    input  erttr_pkg::t_slot_entry        i_wdata,
    input  wire [erttr_pkg::IDX_W-1:0]    i_raddr,
    output erttr_pkg::t_slot_entry        o_rdata
);
    import erttr_pkg::*;

    t_slot_entry r_mem [TABLE_DEPTH];
    t_slot_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[sv/erttr_div.sv]
`default_nettype none
module erttr_div (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_start,
    input  wire [erttr_pkg::TIME_WIDTH-1:0]    i_dividend,
    output logic                               o_busy,
    output logic                               o_done,
    output logic [erttr_pkg::TIME_WIDTH-1:0]   o_quotient
);
    import erttr_pkg::*;

    localparam int STEPS = (TIME_WIDTH + DIV_BITS - 1) / DIV_BITS;
    localparam int PAD_W = STEPS * DIV_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [PAD_W-1:0]    r_dvd;
    logic [PAD_W-1:0]    r_quo;
    logic [REM_W-1:0]    r_rem;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [REM_W-1:0]    n_rem;
    logic [DIV_BITS-1:0] n_qbits;

    // Restoring long division, DIV_BITS quotient bits per cycle.
    always_comb begin
        logic [REM_W:0] trial;
        n_rem   = r_rem;
        n_qbits = '0;
        for (int k = 0; k < DIV_BITS; k++) begin
            trial = {n_rem, r_dvd[PAD_W-1-k]};
            if (trial >= (REM_W+1)'(US_PER_MS)) begin
                n_rem                  = REM_W'(trial - (REM_W+1)'(US_PER_MS));
                n_qbits[DIV_BITS-1-k]  = 1'b1;
            end else begin
                n_rem = REM_W'(trial);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= PAD_W'(i_dividend);
            r_quo <= '0;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << DIV_BITS;
            r_quo <= {r_quo[PAD_W-DIV_BITS-1:0], n_qbits};
            r_rem <= n_rem;
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(STEPS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_W'(STEPS - 1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo[TIME_WIDTH-1:0];

endmodule
`default_nettype wire

[sv/echo_request_tracker.sv]
`default_nettype none
// Echo request tracker: keeps a table of outstanding echo requests and
// reports the round-trip time of matching replies. A send request takes the
// lowest free slot, records the running 16-bit sequence and the send time,
// and advances the send counter (also when the table is full). A reply
// request is checked for length, then type and identifier, then matched to
// the lowest valid slot holding its sequence; that slot is freed and the RTT
// (modular microsecond difference, divided by 1000) is reported. Requests are
// handled one at a time. The slot valid bits live in flip-flops cleared at
// reset, so the block is usable from the first cycle after reset; sequence
// and send time live in a one-port-read, one-port-write RAM. The time per
// request is set by the slot scan, one slot per cycle: a send scans up to
// the slot it takes (the whole table when full); a matched reply scans up
// to its slot, then waits for the RAM read and the divider (12 steps of 4
// quotient bits, then the done strobe); an unknown sequence scans the whole
// table; a short or ignored reply skips the scan. A finished result waits
// in the output register while the next request is taken.
module echo_request_tracker (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  erttr_pkg::t_request   i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output erttr_pkg::t_result    o_out_data,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire [15:0]            i_cfg_data
);
    import erttr_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FREE = 3'd1;
    localparam logic [2:0] S_SEQ  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // Control state
    logic [2:0]             r_state, n_state;
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    logic [15:0]            r_send_cnt, n_send_cnt;
    logic [15:0]            r_recv_cnt, n_recv_cnt;
    logic                   r_out_valid, n_out_valid;
    logic                   r_issue, n_issue;
    logic                   r_cmp_vld, n_cmp_vld;
    logic [15:0]            r_own_id;

    // Payload
    t_request               r_req, n_req;
    t_result                r_res, n_res;
    t_result                r_out_data, n_out_data;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [IDX_W-1:0]       r_cmp_idx, n_cmp_idx;

    logic                   w_in_fire;
    logic                   w_short;
    logic                   w_match;
    logic [TIME_WIDTH-1:0]  w_now;
    logic [TIME_WIDTH-1:0]  w_diff;

    logic                   ram_we;
    t_slot_entry            ram_wdata;
    t_slot_entry            ram_rdata;

    logic                   div_start;
    logic                   div_busy;
    logic                   div_done;
    logic [TIME_WIDTH-1:0]  div_quotient;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign w_in_fire = i_in_valid && o_in_ready;

    // Payload after the header must hold at least MIN_PAYLOAD bytes.
    assign w_short = {1'b0, i_in_data.packet_length}
                   < ((LEN_W+1)'(i_in_data.header_words) << 2) + (LEN_W+1)'(MIN_PAYLOAD);

    assign w_now   = TIME_WIDTH'(r_req.now_us);
    assign w_diff  = w_now - ram_rdata.stamp;

    // RAM data belongs to r_cmp_idx; valid bits do not change during the scan.
    assign w_match = r_cmp_vld && r_valid[r_cmp_idx] && (ram_rdata.seq == r_req.reply_seq);

    assign ram_we    = (r_state == S_FREE) && !r_valid[r_idx];
    assign ram_wdata = '{seq: r_send_cnt, stamp: w_now};
    assign div_start = (r_state == S_SEQ) && w_match;

    erttr_slot_ram u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    erttr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (w_diff),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_send_cnt  = r_send_cnt;
        n_recv_cnt  = r_recv_cnt;
        n_out_valid = r_out_valid;
        n_issue     = r_issue;
        n_cmp_vld   = r_cmp_vld;
        n_req       = r_req;
        n_res       = r_res;
        n_out_data  = r_out_data;
        n_idx       = r_idx;
        n_cmp_idx   = r_cmp_idx;

        // Drop the result once taken; a new one may load in the same cycle.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_req     = i_in_data;
                    n_res     = '0;
                    n_idx     = '0;
                    n_issue   = 1'b1;
                    n_cmp_vld = 1'b0;
                    if (i_in_data.operation == OP_SEND) begin
                        n_state = S_FREE;
                    end else if (w_short) begin
                        n_res.status = ST_SHORT;
                        n_state      = S_DONE;
                    end else if ((i_in_data.reply_type != ICMP_ECHO_REPLY)
                              || (i_in_data.reply_id != r_own_id)) begin
                        n_res.status = ST_IGNORED;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_SEQ;
                    end
                end
            end

            // Scan valid bits for the lowest free slot.
            S_FREE: begin
                if (!r_valid[r_idx]) begin
                    n_valid[r_idx] = 1'b1;
                    n_res.status   = ST_TRACKED;
                    n_res.seq_out  = r_send_cnt;
                    n_res.slot_out = SLOT_W'(r_idx);
                    n_send_cnt     = r_send_cnt + 16'd1;
                    n_state        = S_DONE;
                end else if (r_idx == LAST_IDX) begin
                    n_res.status   = ST_UNTRACKED;
                    n_res.seq_out  = r_send_cnt;
                    n_send_cnt     = r_send_cnt + 16'd1;
                    n_state        = S_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            // Issue one RAM read per cycle, compare its data in the cycle after.
            S_SEQ: begin
                n_cmp_vld = r_issue;
                n_cmp_idx = r_idx;
                if (r_issue) begin
                    if (r_idx == LAST_IDX) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
                if (w_match) begin
                    n_valid[r_cmp_idx] = 1'b0;
                    n_res.status       = ST_MATCHED;
                    n_res.seq_out      = r_req.reply_seq;
                    n_res.slot_out     = SLOT_W'(r_cmp_idx);
                    n_recv_cnt         = r_recv_cnt + 16'd1;
                    n_state            = S_DIV;
                end else if (r_cmp_vld && (r_cmp_idx == LAST_IDX)) begin
                    n_res.status = ST_UNKNOWN;
                    n_state      = S_DONE;
                end
            end

            S_DIV: begin
                if (div_done) begin
                    n_res.rtt_ms = RTT_W'(div_quotient);
                    n_state      = S_DONE;
                end
            end

            // Hold until the output register is free.
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_data                = r_res;
                    n_out_data.sent_total     = r_send_cnt;
                    n_out_data.received_total = r_recv_cnt;
                    n_out_valid               = 1'b1;
                    n_state                   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_send_cnt  <= '0;
            r_recv_cnt  <= '0;
            r_out_valid <= 1'b0;
            r_issue     <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_own_id    <= '0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_send_cnt  <= n_send_cnt;
            r_recv_cnt  <= n_recv_cnt;
            r_out_valid <= n_out_valid;
            r_issue     <= n_issue;
            r_cmp_vld   <= n_cmp_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_own_id <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_res      <= n_res;
        r_out_data <= n_out_data;
        r_idx      <= n_idx;
        r_cmp_idx  <= n_cmp_idx;
    end

    // A free slot found by the scan is marked taken.
    a_slot_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FREE && !r_valid[r_idx]) |=> r_valid[$past(r_idx)])
        else $error("free slot not marked taken");

    // A matched slot is freed.
    a_slot_freed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEQ && w_match) |=> !r_valid[$past(r_cmp_idx)])
        else $error("matched slot not freed");

    // The divider only runs while the control waits for it.
    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> (r_state == S_DIV))
        else $error("divider busy outside divide state");

    // Only a match carries a nonzero RTT.
    a_rtt_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_MATCHED)) |-> (o_out_data.rtt_ms == '0))
        else $error("RTT reported without a match");

endmodule
`default_nettype wire

[tb/erttr_result_checker.sv]
`timescale 1ns / 100ps
module erttr_result_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_in_ready,
    input  erttr_pkg::t_request  i_in_data,
    input  wire                  i_out_valid,
    input  wire                  i_out_ready,
    input  erttr_pkg::t_result   i_out_data,
    input  wire                  i_cfg_valid,
    input  wire                  i_cfg_ready,
    input  wire [15:0]           i_cfg_data,
    output int                   o_pending,
    output int                   o_failures
);
    import erttr_pkg::*;

    logic                  slot_busy  [TABLE_DEPTH];
    logic [15:0]           slot_seq   [TABLE_DEPTH];
    logic [TIME_WIDTH-1:0] slot_stamp [TABLE_DEPTH];
    logic [15:0]           send_count;
    logic [15:0]           match_count;
    logic [15:0]           host_id;
    t_result               awaited_results[$];
    t_result               want;
    int                    failures = 0;

    // Advance the tracker copy by one request and return the result it owes.
    function automatic t_result track_request(input t_request req);
        t_result               res;
        logic [TIME_WIDTH-1:0] span;
        int                    k;
        res = '0;
        if (req.operation == OP_SEND) begin
            res.status  = ST_UNTRACKED;
            res.seq_out = send_count;
            for (k = 0; k < TABLE_DEPTH; k++) begin
                if (!slot_busy[k] && res.status == ST_UNTRACKED) begin
                    slot_busy[k]  = 1'b1;
                    slot_seq[k]   = send_count;
                    slot_stamp[k] = req.now_us;
                    res.status    = ST_TRACKED;
                    res.slot_out  = SLOT_W'(k);
                end
            end
            send_count++;
        end else if (int'(req.packet_length) < int'(req.header_words) * 4 + MIN_PAYLOAD) begin
            res.status = ST_SHORT;
        end else if (req.reply_type != ICMP_ECHO_REPLY || req.reply_id != host_id) begin
            res.status = ST_IGNORED;
        end else begin
            res.status = ST_UNKNOWN;
            for (k = 0; k < TABLE_DEPTH; k++) begin
                if (slot_busy[k] && slot_seq[k] == req.reply_seq && res.status == ST_UNKNOWN) begin
                    slot_busy[k] = 1'b0;
                    span         = req.now_us - slot_stamp[k];
                    res.rtt_ms   = RTT_W'(span / TIME_WIDTH'(US_PER_MS));
                    res.status   = ST_MATCHED;
                    res.seq_out  = req.reply_seq;
                    res.slot_out = SLOT_W'(k);
                    match_count++;
                end
            end
        end
        res.sent_total     = send_count;
        res.received_total = match_count;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                slot_busy[k] = 1'b0;
            end
            send_count  = '0;
            match_count = '0;
            host_id     = '0;
            awaited_results.delete();
        end else begin
            // check the outgoing result before taking a new request in
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("unexpected result: status %0d seq %h slot %0d rtt %0d",
                                 i_out_data.status, i_out_data.seq_out,
                                 i_out_data.slot_out, i_out_data.rtt_ms);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    if (i_out_data.status !== want.status ||
                        i_out_data.seq_out !== want.seq_out ||
                        i_out_data.slot_out !== want.slot_out ||
                        i_out_data.rtt_ms !== want.rtt_ms ||
                        i_out_data.sent_total !== want.sent_total ||
                        i_out_data.received_total !== want.received_total) begin
                        failures++;
                        if (failures <= 10) begin
                            $display("mismatch: expected status %0d seq %h slot %0d rtt %0d ",
                                     want.status, want.seq_out, want.slot_out, want.rtt_ms,
                                     "sent %0d rcvd %0d; ",
                                     want.sent_total, want.received_total,
                                     "actual status %0d seq %h slot %0d rtt %0d ",
                                     i_out_data.status, i_out_data.seq_out,
                                     i_out_data.slot_out, i_out_data.rtt_ms,
                                     "sent %0d rcvd %0d",
                                     i_out_data.sent_total, i_out_data.received_total);
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                host_id = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                awaited_results.push_back(track_request(i_in_data));
            end
        end
        o_pending  <= awaited_results.size();
        o_failures <= failures;
    end

endmodule

[tb/tb_echo_request_tracker.sv]
`timescale 1ns / 100ps
module tb_echo_request_tracker;
    import erttr_pkg::*;

    // Generous bound for about 1500 requests.
    localparam int CYCLE_LIMIT   = 1_000_000;
    // Send/reply pairs in the stretch where neither side idles.
    localparam int NO_IDLE_PAIRS = 60;
    // Longer than the slowest request (full scan plus divider).
    localparam int SETTLE_CYCLES = 200;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_request    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_result     out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;

    // Set for the stretch where neither side idles.
    logic        no_idle   = 1'b0;

    int          pending;
    int          failures;
    int          cycle_count = 0;

    // Stimulus-side bookkeeping only: identifier in force, next sequence the
    // block will hand out, and the sequences still outstanding in its table.
    logic [15:0] host_id  = '0;
    logic [15:0] next_seq = '0;
    logic [15:0] outstanding_seqs[$];
    logic [47:0] clock_us = '0;

    echo_request_tracker DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    erttr_result_checker u_result_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_failures  (failures)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 0;
    end

    // Stall the result side about 30% of the time, never in the no-idle stretch.
    always @(posedge clk) begin
        out_ready <= no_idle || ($urandom_range(99) >= 30);
    end

    // Advance the free-running microsecond clock; now and then jump anywhere
    // so that large and wrapping round trips show up.
    function automatic logic [47:0] next_time();
        if ($urandom_range(99) < 5) begin
            clock_us = 48'({$urandom, $urandom});
        end else begin
            clock_us = clock_us + 48'($urandom_range(4000));
        end
        return clock_us;
    endfunction

    // Send request: the reply fields ride along with random content.
    function automatic t_request send_item();
        t_request r;
        r.operation     = OP_SEND;
        r.now_us        = next_time();
        r.reply_seq     = 16'($urandom);
        r.reply_type    = 8'($urandom);
        r.reply_id      = 16'($urandom);
        r.packet_length = 16'($urandom);
        r.header_words  = 4'($urandom);
        return r;
    endfunction

    function automatic t_request reply_item(input logic [15:0] seq, input logic [7:0] rtype,
                                            input logic [15:0] rid, input logic [15:0] plen,
                                            input logic [3:0] hw);
        t_request r;
        r.operation     = OP_REPLY;
        r.now_us        = next_time();
        r.reply_seq     = seq;
        r.reply_type    = rtype;
        r.reply_id      = rid;
        r.packet_length = plen;
        r.header_words  = hw;
        return r;
    endfunction

    // Length that passes the payload check; hit the exact minimum often.
    function automatic logic [15:0] good_length(input logic [3:0] hw);
        int floor_len;
        floor_len = int'(hw) * 4 + MIN_PAYLOAD;
        if ($urandom_range(3) == 0) begin
            return 16'(floor_len);
        end
        return 16'($urandom_range(65535, floor_len));
    endfunction

    // Mostly well-formed traffic (sends, replies to outstanding requests),
    // the rest short, ignored, unknown-sequence or fully random replies.
    function automatic t_request random_item(input int send_pct, input int good_pct);
        t_request   r;
        int         roll;
        logic [3:0] hw;
        roll = $urandom_range(99);
        hw   = 4'($urandom);
        r    = send_item();
        if (roll < send_pct) begin
            return r;
        end
        r.operation    = OP_REPLY;
        r.header_words = hw;
        if (roll < send_pct + good_pct && outstanding_seqs.size() > 0) begin
            r.reply_seq     = outstanding_seqs[$urandom_range(outstanding_seqs.size() - 1)];
            r.reply_type    = ICMP_ECHO_REPLY;
            r.reply_id      = host_id;
            r.packet_length = good_length(hw);
            return r;
        end
        case ($urandom_range(3))
            0: ;
            1: r.packet_length = 16'($urandom_range(int'(hw) * 4 + MIN_PAYLOAD - 1));
            2: begin
                // right size, wrong type or wrong identifier
                r.packet_length = good_length(hw);
                if ($urandom_range(1) == 1) begin
                    r.reply_type = 8'($urandom_range(255, 1));
                end else begin
                    r.reply_type = ICMP_ECHO_REPLY;
                    r.reply_id   = host_id ^ 16'($urandom_range(65535, 1));
                end
                if (outstanding_seqs.size() > 0 && $urandom_range(1) == 1) begin
                    r.reply_seq = outstanding_seqs[$urandom_range(outstanding_seqs.size() - 1)];
                end
            end
            default: begin
                // valid reply carrying a random, most likely unknown, sequence
                r.packet_length = good_length(hw);
                r.reply_type    = ICMP_ECHO_REPLY;
                r.reply_id      = host_id;
            end
        endcase
        return r;
    endfunction

    // Offer one request and hold it until accepted. Valid is only lowered
    // while idling, so back-to-back requests never see valid dip.
    task automatic offer_request(input t_request req);
        int i;
        while (!no_idle && $urandom_range(99) < 30) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        // track table occupancy so later replies can target live requests
        if (req.operation == OP_SEND) begin
            if (outstanding_seqs.size() < TABLE_DEPTH) begin
                outstanding_seqs.push_back(next_seq);
            end
            next_seq++;
        end else if (int'(req.packet_length) >= int'(req.header_words) * 4 + MIN_PAYLOAD &&
                     req.reply_type == ICMP_ECHO_REPLY && req.reply_id == host_id) begin
            i = 0;
            while (i < outstanding_seqs.size() && outstanding_seqs[i] != req.reply_seq) begin
                i++;
            end
            if (i < outstanding_seqs.size()) begin
                outstanding_seqs.delete(i);
            end
        end
    endtask

    // Drop valid and hold until every request in flight has produced its result.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Write the identifier only with the block idle.
    task automatic write_identifier(input logic [15:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        host_id = value;
    endtask

    task automatic run_phase(input int count, input int send_pct, input int good_pct);
        repeat (count) offer_request(random_item(send_pct, good_pct));
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_echo_request_tracker NOT OK");
        $finish;
    end

    initial begin
        t_request    req;
        logic [15:0] base_seq;
        int          n;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests, identifier still at its reset value of zero.
        // Send at time zero with all-zero fields, then one at the last
        // microsecond with every ignored field set.
        req = '0;
        req.operation = OP_SEND;
        offer_request(req);
        req = '1;
        req.operation = OP_SEND;
        offer_request(req);
        // reply to the second send after the time wrapped
        req = reply_item(16'd1, ICMP_ECHO_REPLY, 16'h0000, 16'hFFFF, 4'd0);
        req.now_us = 48'h0000_0000_1000;
        offer_request(req);
        // reply to the first send at the last microsecond: largest RTT
        req = reply_item(16'd0, ICMP_ECHO_REPLY, 16'h0000, 16'd28, 4'd5);
        req.now_us = '1;
        offer_request(req);
        // same sequence again: slot already freed
        offer_request(reply_item(16'd0, ICMP_ECHO_REPLY, 16'h0000, 16'd28, 4'd5));
        // length checks: empty, header past the packet, one byte short, exact
        offer_request(reply_item(16'h1234, ICMP_ECHO_REPLY, 16'h0000, 16'd0, 4'd0));
        offer_request(reply_item(16'h1234, ICMP_ECHO_REPLY, 16'h0000, 16'd20, 4'd15));
        offer_request(reply_item(16'h1234, ICMP_ECHO_REPLY, 16'h0000, 16'd67, 4'd15));
        offer_request(reply_item(16'h1234, ICMP_ECHO_REPLY, 16'h0000, 16'd68, 4'd15));
        offer_request(reply_item(16'hFFFF, ICMP_ECHO_REPLY, 16'h0000, 16'd7, 4'd0));
        offer_request(reply_item(16'hFFFF, ICMP_ECHO_REPLY, 16'h0000, 16'd8, 4'd0));
        // wrong type, echo request type, wrong identifier
        offer_request(reply_item(16'h0000, 8'hFF, 16'h0000, 16'd64, 4'd5));
        offer_request(reply_item(16'h0000, 8'd8, 16'h0000, 16'd64, 4'd5));
        offer_request(reply_item(16'h0000, ICMP_ECHO_REPLY, 16'hFFFF, 16'd64, 4'd5));
        // too short and wrong type at once: the length check comes first
        offer_request(reply_item(16'h0000, 8'hFF, 16'hFFFF, 16'd3, 4'd15));
        // three sends at one time into slots 0..2
        repeat (3) begin
            req = send_item();
            req.now_us = 48'd5000;
            offer_request(req);
        end
        // free the middle slot after exactly one millisecond
        req = reply_item(16'd3, ICMP_ECHO_REPLY, 16'h0000, 16'd100, 4'd5);
        req.now_us = 48'd6000;
        offer_request(req);
        // next send fills the hole in the middle
        offer_request(send_item());
        // just under a millisecond rounds down to zero
        req = reply_item(16'd2, ICMP_ECHO_REPLY, 16'h0000, 16'd100, 4'd5);
        req.now_us = 48'd5999;
        offer_request(req);

        // Random phases, each under its own identifier.
        write_identifier(16'hFFFF);
        run_phase(300, 45, 35);
        // mostly sends: fill the table and keep sending while full
        write_identifier(16'h0000);
        run_phase(250, 85, 5);
        // mostly replies: drain it again
        write_identifier(16'($urandom));
        run_phase(250, 20, 65);
        write_identifier(16'($urandom));
        run_phase(300, 45, 35);

        // Empty the table, then park one request in slot 3 while the slots
        // below it are reused.
        while (outstanding_seqs.size() > 0) begin
            offer_request(reply_item(outstanding_seqs[0], ICMP_ECHO_REPLY, host_id,
                                     16'd84, 4'd5));
        end
        base_seq = next_seq;
        repeat (4) offer_request(send_item());
        for (n = 0; n < 3; n++) begin
            offer_request(reply_item(base_seq + 16'(n), ICMP_ECHO_REPLY, host_id,
                                     16'd84, 4'd5));
        end

        // No idling on either side: send/reply pairs through slot 0.
        no_idle <= 1'b1;
        repeat (NO_IDLE_PAIRS) begin
            offer_request(send_item());
            offer_request(reply_item(next_seq - 16'd1, ICMP_ECHO_REPLY, host_id,
                                     16'd84, 4'd5));
        end
        no_idle <= 1'b0;

        // Mixed traffic with the parked request still outstanding.
        write_identifier(16'($urandom));
        run_phase(150, 40, 40);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0) begin
            $display("tb_echo_request_tracker OK");
        end else begin
            $display("tb_echo_request_tracker NOT OK");
        end
        $finish;
    end

endmodule
